FILE: sv/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// LSB stego package
// Shared types, codes and defaults for the LSB embed/extract core.
// ----------------------------------------------------------------------------
package lsbse_pkg;

  localparam int unsigned HEADER_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN = 2'd1;

  typedef enum logic [1:0] {
    KIND_CARRIER = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_LENGTH  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [31:0] found_length;
    logic        last;
    status_e     status;
  } result_t;

endpackage

FILE: sv/lsbse_engine.sv
// ----------------------------------------------------------------------------
// LSB stego engine
// Stream state, config registers and the single-pass embed/extract logic.
// ----------------------------------------------------------------------------
module lsbse_engine #(
  parameter int unsigned HEADER_BITS = lsbse_pkg::HEADER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsbse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           item_we_i,
  input  logic                           action_i,
  input  logic [7:0]                     carrier_byte_i,
  input  logic [7:0]                     payload_byte_i,
  output logic                           res_valid_o,
  output lsbse_pkg::result_t             res_o
);
  import lsbse_pkg::*;

  localparam int unsigned PosW    = HEADER_BITS + 4;
  localparam int unsigned HdrIdxW = $clog2(HEADER_BITS);

  logic                   mode_q, mode_d;
  logic [31:0]            plen_q, plen_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [HEADER_BITS-1:0] lenreg_q, lenreg_d;
  logic [7:0]             shift_q, shift_d;
  logic                   pend_q, pend_d;

  logic [HEADER_BITS-1:0] len_hdr;
  logic [HEADER_BITS-1:0] lenreg_next;
  logic [PosW-1:0]        total_emb, total_ext, pos_inc, pay_off, inc_off;
  logic [HdrIdxW-1:0]     hdr_idx;
  logic [2:0]             pay_idx;
  logic                   in_hdr, emb_bit;
  logic [7:0]             shift_next;

  assign len_hdr     = plen_q[HEADER_BITS-1:0];
  assign total_emb   = PosW'(HEADER_BITS) + PosW'({len_hdr, 3'b000});
  assign total_ext   = PosW'(HEADER_BITS) + PosW'({lenreg_q, 3'b000});
  assign pos_inc     = pos_q + PosW'(1);
  assign in_hdr      = pos_q < PosW'(HEADER_BITS);
  assign hdr_idx     = HdrIdxW'(HEADER_BITS - 1) - pos_q[HdrIdxW-1:0];
  assign pay_off     = pos_q - PosW'(HEADER_BITS);
  assign inc_off     = pos_inc - PosW'(HEADER_BITS);
  assign pay_idx     = pay_off[2:0];
  assign lenreg_next = {lenreg_q[HEADER_BITS-2:0], carrier_byte_i[0]};
  assign shift_next  = {shift_q[6:0], carrier_byte_i[0]};
  assign emb_bit     = in_hdr ? len_hdr[hdr_idx] : shift_q[~pay_idx];

  always_comb begin
    mode_d      = mode_q;
    plen_d      = plen_q;
    pos_d       = pos_q;
    lenreg_d    = lenreg_q;
    shift_d     = shift_q;
    pend_d      = pend_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_MODE) begin
        mode_d   = cfg_data_i[0];
        pos_d    = '0;
        lenreg_d = '0;
        shift_d  = '0;
        pend_d   = 1'b0;
      end else if (cfg_index_i == CFG_PLEN) begin
        plen_d = cfg_data_i;
      end
    end else if (item_we_i) begin
      if (!mode_q) begin
        if (action_i) begin
          if (pend_q) begin
            res_valid_o  = 1'b1;
            res_o.status = STATUS_IGNORED;
          end else begin
            shift_d = payload_byte_i;
            pend_d  = 1'b1;
          end
        end else if (pos_q >= total_emb) begin
          res_valid_o    = 1'b1;
          res_o.out_byte = carrier_byte_i;
        end else if (!in_hdr && !pend_q) begin
          res_valid_o    = 1'b1;
          res_o.out_byte = carrier_byte_i;
          res_o.status   = STATUS_MISSING;
        end else begin
          if (!in_hdr && pay_idx == 3'd7) begin
            pend_d = 1'b0;
          end
          pos_d          = pos_inc;
          res_valid_o    = 1'b1;
          res_o.out_byte = {carrier_byte_i[7:1], emb_bit};
          res_o.last     = pos_inc == total_emb;
        end
      end else if (!action_i) begin
        if (in_hdr) begin
          lenreg_d = lenreg_next;
          pos_d    = pos_inc;
          if (pos_inc == PosW'(HEADER_BITS)) begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_LENGTH;
            res_o.found_length = 32'(lenreg_next);
            res_o.last         = lenreg_next == '0;
          end
        end else if (pos_q < total_ext) begin
          shift_d = shift_next;
          pos_d   = pos_inc;
          if (inc_off[2:0] == 3'd0) begin
            res_valid_o    = 1'b1;
            res_o.kind     = KIND_PAYLOAD;
            res_o.out_byte = shift_next;
            res_o.last     = pos_inc == total_ext;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      plen_q   <= '0;
      pos_q    <= '0;
      lenreg_q <= '0;
      shift_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      plen_q   <= plen_d;
      pos_q    <= pos_d;
      lenreg_q <= lenreg_d;
      shift_q  <= shift_d;
      pend_q   <= pend_d;
    end
  end

  // pending byte is consumed only by an embed carrier or a stream restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) |-> $past(cfg_we_i || (item_we_i && !action_i && !mode_q)))
    else $error("pending payload byte dropped unexpectedly");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == STATUS_IGNORED) |-> (pend_q && !mode_q))
    else $error("load ignored without a pending byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_LENGTH) |->
      (mode_q && pos_q == PosW'(HEADER_BITS - 1)))
    else $error("length report outside header end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) |-> (pos_q == $past(pos_q) || pos_q == $past(pos_q) + PosW'(1)))
    else $error("bit position jumped");

endmodule

FILE: sv/lsbse_obuf.sv
// ----------------------------------------------------------------------------
// LSB stego output buffer
// Two-entry result queue that decouples the engine from output stalls.
// ----------------------------------------------------------------------------
module lsbse_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lsbse_pkg::result_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               ready_i,
  output lsbse_pkg::result_t data_o
);
  import lsbse_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: sv/lsb_stego_embed_extract_core.sv
// ----------------------------------------------------------------------------
// LSB stego embed/extract core
// Hides a length header and payload bytes in carrier LSBs, or recovers them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one transaction per item:
//   action_i = 0 is a carrier byte, action_i = 1 loads the next payload byte.
//   Output channel (out_valid_o/out_ready_i) returns modified carrier bytes,
//   extracted payload bytes or the decoded length report.
//   Config channel (cfg_valid_i/cfg_ready_o) writes mode (index 0) or
//   payload_length (index 1); it is always ready. Writing mode restarts the
//   stream. Write config only while the core is idle.
//   A result is registered in the result queue when its input transaction
//   is taken and shows once older entries have left. One input transaction
//   per cycle is sustained while in_ready_o is high; the single
//   combinational pass between stream registers and queue sets that rate.
//   A two-entry result queue absorbs output stalls; in_ready_o drops only
//   while both entries are held.
//   Reset returns to embed mode, zero length and an empty queue.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_core #(
  parameter int unsigned HEADER_BITS = lsbse_pkg::HEADER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsbse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [7:0]                      carrier_byte_i,
  input  logic [7:0]                      payload_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      kind_o,
  output logic [7:0]                      out_byte_o,
  output logic [31:0]                     found_length_o,
  output logic                            last_o,
  output logic [1:0]                      status_o
);
  import lsbse_pkg::*;

  logic    full, item_we, res_valid;
  result_t res, out_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign item_we     = in_valid_i && in_ready_o;

  lsbse_engine #(
    .HEADER_BITS(HEADER_BITS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_we_i      (item_we),
    .action_i       (action_i),
    .carrier_byte_i (carrier_byte_i),
    .payload_byte_i (payload_byte_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  lsbse_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign kind_o         = out_res.kind;
  assign out_byte_o     = out_res.out_byte;
  assign found_length_o = out_res.found_length;
  assign last_o         = out_res.last;
  assign status_o       = out_res.status;

endmodule
